FILE: sv/dht_pkg.sv
`timescale 1ns / 1ps

package dht_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_LIMIT  = 31;
    // Slot numbers are five bits wide, so at most 31 entries can be reached.
    localparam int USED_DEPTH  = (TABLE_DEPTH < SLOT_LIMIT) ? TABLE_DEPTH : SLOT_LIMIT;
    localparam int SLOT_W      = 5;
    localparam int KEY_W       = 32;
    localparam int FUNC_W      = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_LOOKUP  = 2'd1,
        FUNC_RELEASE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // Request token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic              active;
        func_t             op;
        logic [KEY_W-1:0]  hkey;
        logic [KEY_W-1:0]  ckey;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] match_slot;
        logic [SLOT_W-1:0] empty_slot;
        logic [KEY_W-1:0]  data_h;
        logic [KEY_W-1:0]  data_c;
    } probe_t;

    // Entry write issued by the controller after an allocate scan.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  hkey;
        logic [KEY_W-1:0]  ckey;
    } wr_t;

endpackage

FILE: sv/dht_cell.sv
`timescale 1ns / 1ps

module dht_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dht_pkg::SLOT_W-1:0] cell_slot,
    input  dht_pkg::probe_t            probe_in,
    input  dht_pkg::wr_t               wr,
    output dht_pkg::probe_t            probe_out
);

    logic [dht_pkg::KEY_W-1:0] handler_reg;
    logic [dht_pkg::KEY_W-1:0] handler_next;
    logic [dht_pkg::KEY_W-1:0] context_reg;
    logic [dht_pkg::KEY_W-1:0] context_next;
    dht_pkg::probe_t           probe_reg;
    dht_pkg::probe_t           probe_next;

    always_comb
    begin
        handler_next = handler_reg;
        context_next = context_reg;
        probe_next   = probe_in;
        if (wr.en && (wr.slot == cell_slot))
        begin
            handler_next = wr.hkey;
            context_next = wr.ckey;
        end
        if (probe_in.active)
        begin
            case (probe_in.op)
                dht_pkg::FUNC_ALLOC:
                begin
                    // The first matching pair and the first empty entry win.
                    if ((probe_in.match_slot == '0) && (handler_reg == probe_in.hkey) &&
                        (context_reg == probe_in.ckey))
                    begin
                        probe_next.match_slot = cell_slot;
                    end
                    if ((probe_in.empty_slot == '0) && (handler_reg == '0))
                    begin
                        probe_next.empty_slot = cell_slot;
                    end
                end
                dht_pkg::FUNC_LOOKUP:
                begin
                    if (probe_in.slot == cell_slot)
                    begin
                        probe_next.data_h = handler_reg;
                        probe_next.data_c = context_reg;
                    end
                end
                dht_pkg::FUNC_RELEASE:
                begin
                    if (probe_in.slot == cell_slot)
                    begin
                        handler_next = '0;
                        context_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handler_reg <= '0;
            context_reg <= '0;
            probe_reg   <= '0;
        end
        else
        begin
            handler_reg <= handler_next;
            context_reg <= context_next;
            probe_reg   <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

FILE: sv/dht_ctrl.sv
`timescale 1ns / 1ps

module dht_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  dht_pkg::probe_t            tail,
    output dht_pkg::wr_t               wr,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [dht_pkg::SLOT_W-1:0] result_slot,
    output logic [dht_pkg::KEY_W-1:0]  found_handler,
    output logic [dht_pkg::KEY_W-1:0]  found_context
);

    dht_pkg::state_t           state_reg;
    dht_pkg::state_t           state_next;
    dht_pkg::wr_t              wr_reg;
    dht_pkg::wr_t              wr_next;
    logic [dht_pkg::SLOT_W-1:0] res_slot_reg;
    logic [dht_pkg::SLOT_W-1:0] res_slot_next;
    logic [dht_pkg::KEY_W-1:0]  res_h_reg;
    logic [dht_pkg::KEY_W-1:0]  res_h_next;
    logic [dht_pkg::KEY_W-1:0]  res_c_reg;
    logic [dht_pkg::KEY_W-1:0]  res_c_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [dht_pkg::SLOT_W-1:0] out_slot_reg;
    logic [dht_pkg::SLOT_W-1:0] out_slot_next;
    logic [dht_pkg::KEY_W-1:0]  out_h_reg;
    logic [dht_pkg::KEY_W-1:0]  out_h_next;
    logic [dht_pkg::KEY_W-1:0]  out_c_reg;
    logic [dht_pkg::KEY_W-1:0]  out_c_next;

    always_comb
    begin
        state_next     = state_reg;
        wr_next        = wr_reg;
        wr_next.en     = 1'b0;
        res_slot_next  = res_slot_reg;
        res_h_next     = res_h_reg;
        res_c_next     = res_c_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_slot_next  = out_slot_reg;
        out_h_next     = out_h_reg;
        out_c_next     = out_c_reg;
        in_stall       = 1'b1;
        case (state_reg)
            dht_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = dht_pkg::ST_SCAN;
                end
            end
            dht_pkg::ST_SCAN:
            begin
                if (tail.active)
                begin
                    res_slot_next = '0;
                    res_h_next    = '0;
                    res_c_next    = '0;
                    wr_next.slot  = tail.empty_slot;
                    wr_next.hkey  = tail.hkey;
                    wr_next.ckey  = tail.ckey;
                    case (tail.op)
                        dht_pkg::FUNC_ALLOC:
                        begin
                            if (tail.hkey != '0)
                            begin
                                if (tail.match_slot != '0)
                                begin
                                    res_slot_next = tail.match_slot;
                                end
                                else
                                begin
                                    res_slot_next = tail.empty_slot;
                                    wr_next.en    = (tail.empty_slot != '0);
                                end
                            end
                        end
                        dht_pkg::FUNC_LOOKUP:
                        begin
                            res_h_next = tail.data_h;
                            res_c_next = tail.data_c;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = dht_pkg::ST_COMMIT;
                end
            end
            dht_pkg::ST_COMMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = res_slot_reg;
                    out_h_next     = res_h_reg;
                    out_c_next     = res_c_reg;
                    state_next     = dht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dht_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dht_pkg::ST_IDLE;
            wr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_reg        <= wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_slot_reg <= res_slot_next;
        res_h_reg    <= res_h_next;
        res_c_reg    <= res_c_next;
        out_slot_reg <= out_slot_next;
        out_h_reg    <= out_h_next;
        out_c_reg    <= out_c_next;
    end

    assign wr            = wr_reg;
    assign out_valid     = out_valid_reg;
    assign result_slot   = out_slot_reg;
    assign found_handler = out_h_reg;
    assign found_context = out_c_reg;

endmodule

FILE: sv/dedup_handle_table.sv
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     in_valid, in_stall   func, handler_key, context_key, slot_id
// output    out_valid, out_stall result_slot, found_handler, found_context
//
// One request is in flight at a time: the request walks the row of cells one cell
// per cycle, then the controller registers the result and any allocate write, and
// the commit state loads the output register. rst_n clears every entry to empty at
// once, so no clearing pass is needed. A stalled output holds its result, and the
// next request is taken only after the pending result has moved into the output
// register.
module dedup_handle_table
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [dht_pkg::FUNC_W-1:0] func,
    input  logic [dht_pkg::KEY_W-1:0]  handler_key,
    input  logic [dht_pkg::KEY_W-1:0]  context_key,
    input  logic [dht_pkg::SLOT_W-1:0] slot_id,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [dht_pkg::SLOT_W-1:0] result_slot,
    output logic [dht_pkg::KEY_W-1:0]  found_handler,
    output logic [dht_pkg::KEY_W-1:0]  found_context
);

    // Probe link between neighboring cells; link 0 is the new request and the
    // last link returns the gathered answer to the controller.
    dht_pkg::probe_t                 chain [dht_pkg::USED_DEPTH+1];
    dht_pkg::wr_t                    wr;
    logic [dht_pkg::USED_DEPTH-1:0]  active_bits;

    // The request enters the first cell at the edge of its transfer.
    always_comb
    begin
        chain[0]            = '0;
        chain[0].active     = in_valid && !in_stall;
        chain[0].op         = dht_pkg::func_t'(func);
        chain[0].hkey       = handler_key;
        chain[0].ckey       = context_key;
        chain[0].slot       = slot_id;
    end

    // Each cell owns one entry, numbered from slot 1 upward.
    genvar gi;
    generate
        for (gi = 0; gi < dht_pkg::USED_DEPTH; gi++)
        begin : g_cell
            dht_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_slot (dht_pkg::SLOT_W'(gi + 1)),
                .probe_in  (chain[gi]),
                .wr        (wr),
                .probe_out (chain[gi+1])
            );
            assign active_bits[gi] = chain[gi+1].active;
        end
    endgenerate

    dht_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .tail          (chain[dht_pkg::USED_DEPTH]),
        .wr            (wr),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_slot   (result_slot),
        .found_handler (found_handler),
        .found_context (found_context)
    );

`ifndef ASSERT_OFF
    // Only one request may travel along the row at any time.
    a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(active_bits))
        else $error("more than one request in the cell row");

    // While a request is in the row, no new request may be taken.
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (active_bits != '0) |-> in_stall)
        else $error("request taken while the row is busy");

    // An entry write only follows the end of a scan.
    a_write_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> $past(chain[dht_pkg::USED_DEPTH].active))
        else $error("entry write without a finished scan");

    // After a transfer the block stalls until the request is finished.
    a_accept_then_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken back to back");
`endif

endmodule

FILE: tb/tb_dedup_handle_table.sv
`timescale 1ns / 1ps

typedef struct {
    logic [dht_pkg::SLOT_W-1:0] slot;
    logic [dht_pkg::KEY_W-1:0]  handler;
    logic [dht_pkg::KEY_W-1:0]  context_value;
} table_reply_t;

// Mirror of the handle table plus the replies it still owes.
class handle_table_checker;
    bit [dht_pkg::KEY_W-1:0] handler_tbl [dht_pkg::USED_DEPTH];
    bit [dht_pkg::KEY_W-1:0] context_tbl [dht_pkg::USED_DEPTH];
    table_reply_t            expected_replies [$];
    int                      mismatches;

    function void note_request(logic [dht_pkg::FUNC_W-1:0] op,
                               logic [dht_pkg::KEY_W-1:0] hkey,
                               logic [dht_pkg::KEY_W-1:0] ckey,
                               logic [dht_pkg::SLOT_W-1:0] slot);
        table_reply_t reply;
        int           free_slot;
        int           hit_slot;
        bit           in_range;
        reply.slot          = '0;
        reply.handler       = '0;
        reply.context_value = '0;
        in_range = (slot != 0) && (slot <= dht_pkg::USED_DEPTH);
        case (op)
            dht_pkg::FUNC_ALLOC:
            begin
                if (hkey != 0)
                begin
                    free_slot = 0;
                    hit_slot  = 0;
                    for (int i = 0; i < dht_pkg::USED_DEPTH && hit_slot == 0; i++)
                    begin
                        if (handler_tbl[i] == hkey && context_tbl[i] == ckey)
                            hit_slot = i + 1;
                        else if (free_slot == 0 && handler_tbl[i] == 0)
                            free_slot = i + 1;
                    end
                    if (hit_slot != 0)
                        reply.slot = dht_pkg::SLOT_W'(hit_slot);
                    else if (free_slot != 0)
                    begin
                        handler_tbl[free_slot-1] = hkey;
                        context_tbl[free_slot-1] = ckey;
                        reply.slot = dht_pkg::SLOT_W'(free_slot);
                    end
                end
            end
            dht_pkg::FUNC_LOOKUP:
            begin
                if (in_range)
                begin
                    reply.handler       = handler_tbl[slot-1];
                    reply.context_value = context_tbl[slot-1];
                end
            end
            dht_pkg::FUNC_RELEASE:
            begin
                if (in_range)
                begin
                    handler_tbl[slot-1] = '0;
                    context_tbl[slot-1] = '0;
                end
            end
            default:
            begin
            end
        endcase
        expected_replies.push_back(reply);
    endfunction

    function void check_reply(logic [dht_pkg::SLOT_W-1:0] slot,
                              logic [dht_pkg::KEY_W-1:0] handler,
                              logic [dht_pkg::KEY_W-1:0] context_value);
        table_reply_t want;
        if (expected_replies.size() == 0)
        begin
            $display("%0t: result with none expected: slot %0d handler %h context %h",
                     $time, slot, handler, context_value);
            mismatches++;
            return;
        end
        want = expected_replies.pop_front();
        if (slot !== want.slot)
        begin
            $display("%0t: result_slot expected %0d, actual %0d", $time, want.slot, slot);
            mismatches++;
        end
        if (handler !== want.handler)
        begin
            $display("%0t: found_handler expected %h, actual %h", $time, want.handler,
                     handler);
            mismatches++;
        end
        if (context_value !== want.context_value)
        begin
            $display("%0t: found_context expected %h, actual %h", $time,
                     want.context_value, context_value);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_replies.size();
    endfunction
endclass

module tb_dedup_handle_table;

    // Operation code the block does not define; it must change nothing and reply zeros.
    localparam logic [dht_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    // Cycles with no transfer on either channel before the run is declared hung.
    // The long receiver hold-off below is far shorter than this limit, which leaves ample margin.
    localparam int IDLE_LIMIT     = 3000;
    localparam int ITEMS_PER_MIX  = 460;
    localparam int HOLDOFF_CYCLES = 400;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [dht_pkg::FUNC_W-1:0] func;
    logic [dht_pkg::KEY_W-1:0]  handler_key;
    logic [dht_pkg::KEY_W-1:0]  context_key;
    logic [dht_pkg::SLOT_W-1:0] slot_id;
    logic                       out_valid;
    logic                       out_stall;
    logic [dht_pkg::SLOT_W-1:0] result_slot;
    logic [dht_pkg::KEY_W-1:0]  found_handler;
    logic [dht_pkg::KEY_W-1:0]  found_context;

    handle_table_checker table_checker;
    int                  burst_left;
    int                  results_taken;
    int                  idle_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dedup_handle_table i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .handler_key   (handler_key),
        .context_key   (context_key),
        .slot_id       (slot_id),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_slot   (result_slot),
        .found_handler (found_handler),
        .found_context (found_context)
    );

    // Offer one request and hold it until the block takes it. The task is entered
    // at a rising edge and returns at the edge of the transfer, or after the idle gap
    // that closes a burst. Bursts are of random length, and half of the gaps are
    // zero, so long stretches of back-to-back requests occur too.
    task automatic send_request(input logic [dht_pkg::FUNC_W-1:0] op,
                                input logic [dht_pkg::KEY_W-1:0]  hkey,
                                input logic [dht_pkg::KEY_W-1:0]  ckey,
                                input logic [dht_pkg::SLOT_W-1:0] slot);
        int gap;
        in_valid    <= 1'b1;
        func        <= op;
        handler_key <= hkey;
        context_key <= ckey;
        slot_id     <= slot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        table_checker.note_request(op, hkey, ckey, slot);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering and wait until every owed reply has come back. At least one edge
    // passes, so the valid line is never lowered and raised in the same step.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (table_checker.pending() > 0);
    endtask

    // Handler keys come mostly from a small pool so that the same pair is offered
    // again and again, which exercises reuse of a slot and fills the table quickly.
    // A few are zero (refused) and a few are fully random to toggle every bit.
    function automatic logic [dht_pkg::KEY_W-1:0] pick_handler();
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        idx  = $urandom_range(0, 11);
        if (pick < 4)
            return '0;
        if (pick < 12)
            return $urandom;
        case (idx)
            0: return 32'hFFFF_FFFF;
            1: return 32'h0000_0001;
            2: return 32'h8000_0000;
            default: return 32'h1000_0000 * idx + 32'h0000_0101 * idx;
        endcase
    endfunction

    function automatic logic [dht_pkg::KEY_W-1:0] pick_context();
        if ($urandom_range(0, 99) < 15)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0001;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // Most slot numbers address a real entry; the rest span the whole 5-bit field,
    // including zero and numbers past the end of the table.
    function automatic logic [dht_pkg::SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 99) < 80)
            return dht_pkg::SLOT_W'($urandom_range(1, dht_pkg::USED_DEPTH));
        return dht_pkg::SLOT_W'($urandom_range(0, 31));
    endfunction

    // Stimulus: reset, a directed pass over the corner cases, then four random
    // mixes. The allocate-heavy mixes fill the table so that full-table refusals
    // occur, and the release-heavy mix drains it again.
    initial
    begin
        int alloc_pct;
        int lookup_pct;
        int release_pct;
        int pick;
        logic [dht_pkg::FUNC_W-1:0] op;
        table_checker = new();
        burst_left    = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        func          <= dht_pkg::FUNC_ALLOC;
        handler_key   <= '0;
        context_key   <= '0;
        slot_id       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero handler is refused; an identical pair reuses its slot; a second
        // context for the same handler takes a new slot.
        send_request(dht_pkg::FUNC_ALLOC,   32'h0000_0000, 32'hFFFF_FFFF, 5'd31);
        send_request(dht_pkg::FUNC_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
        send_request(dht_pkg::FUNC_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
        send_request(dht_pkg::FUNC_ALLOC,   32'hFFFF_FFFF, 32'h0000_0000, 5'd0);
        send_request(dht_pkg::FUNC_ALLOC,   32'h0000_0001, 32'h0000_0000, 5'd0);
        // Lookups of slot zero, just past the table, the top code, a used and an
        // empty slot.
        send_request(dht_pkg::FUNC_LOOKUP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
        send_request(dht_pkg::FUNC_LOOKUP,  32'h0000_0000, 32'h0000_0000,
                     dht_pkg::SLOT_W'(dht_pkg::USED_DEPTH + 1));
        send_request(dht_pkg::FUNC_LOOKUP,  32'h0000_0000, 32'h0000_0000, 5'd31);
        send_request(dht_pkg::FUNC_LOOKUP,  32'h0000_0000, 32'h0000_0000, 5'd1);
        send_request(dht_pkg::FUNC_LOOKUP,  32'h0000_0000, 32'h0000_0000,
                     dht_pkg::SLOT_W'(dht_pkg::USED_DEPTH));
        send_request(FUNC_UNUSED,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        // Releases outside the table do nothing; a real one frees slot 2, which the
        // next new pair then takes as the lowest empty entry.
        send_request(dht_pkg::FUNC_RELEASE, 32'h0000_0000, 32'h0000_0000, 5'd0);
        send_request(dht_pkg::FUNC_RELEASE, 32'h0000_0000, 32'h0000_0000, 5'd31);
        send_request(dht_pkg::FUNC_RELEASE, 32'h0000_0000, 32'h0000_0000, 5'd2);
        send_request(dht_pkg::FUNC_LOOKUP,  32'h0000_0000, 32'h0000_0000, 5'd2);
        send_request(dht_pkg::FUNC_ALLOC,   32'h0000_0001, 32'h0000_0000, 5'd0);
        send_request(dht_pkg::FUNC_ALLOC,   32'h8000_0000, 32'h1234_5678, 5'd0);

        // The sender pauses here until the block has answered everything.
        wait_for_drain();

        for (int mix = 0; mix < 4; mix++)
        begin
            case (mix)
                0:
                begin
                    alloc_pct = 70; lookup_pct = 15; release_pct = 12;
                end
                1:
                begin
                    alloc_pct = 25; lookup_pct = 35; release_pct = 37;
                end
                2:
                begin
                    alloc_pct = 50; lookup_pct = 25; release_pct = 22;
                end
                default:
                begin
                    alloc_pct = 80; lookup_pct = 10; release_pct = 7;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_MIX; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < alloc_pct)
                    op = dht_pkg::FUNC_ALLOC;
                else if (pick < alloc_pct + lookup_pct)
                    op = dht_pkg::FUNC_LOOKUP;
                else if (pick < alloc_pct + lookup_pct + release_pct)
                    op = dht_pkg::FUNC_RELEASE;
                else
                    op = FUNC_UNUSED;
                if (op == dht_pkg::FUNC_ALLOC)
                    send_request(op, pick_handler(), pick_context(),
                                 dht_pkg::SLOT_W'($urandom_range(0, 31)));
                else
                    send_request(op, $urandom, $urandom, pick_slot());
            end
            if (mix == 1)
                wait_for_drain();
        end

        wait_for_drain();
        // Wait a little longer than one request takes to pass through the block, so that
        // any stray extra result would still be caught.
        repeat (dht_pkg::USED_DEPTH + 8) @(posedge clk);
        if (table_checker.mismatches == 0 && table_checker.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver: checks every result transfer and drives out_stall on a pattern that
    // cycles through no stalls, light and heavy random stalls and a fixed rhythm.
    // Once, after a few hundred results, it holds off for a long stretch while the
    // sender keeps offering, so the block backs up and stalls its input.
    initial
    begin
        int rx_cycle;
        int holdoff_left;
        bit holdoff_done;
        rx_cycle      = 0;
        holdoff_left  = 0;
        holdoff_done  = 1'b0;
        results_taken = 0;
        out_stall     <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                table_checker.check_reply(result_slot, found_handler, found_context);
                results_taken++;
            end
            rx_cycle++;
            if (!holdoff_done && results_taken >= 300)
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case ((rx_cycle / 700) % 4)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= ($urandom_range(0, 99) < 75);
                    default: out_stall <= ((rx_cycle % 6) < 2);
                endcase
            end
        end
    end

    // Watchdog: a hung handshake shows up as a long run of cycles with no transfer.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if ((in_valid && !in_stall) || (out_valid && !out_stall))
                    idle_cycles = 0;
                else
                    idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

endmodule
